### src/slx_pkg.sv
// shared types, token codes and operator tables for the source lexer
package slx_pkg;

    localparam int KIND_W = 6;
    localparam int OFFS_W = 32;
    localparam int LINE_W = 24;
    localparam int FIFO_DEPTH = 8;
    localparam int MAX_TOKENS = 3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [KIND_W-1:0] KIND_DOT      = 6'd16;
    localparam logic [KIND_W-1:0] KIND_OTHER    = 6'd24;
    localparam logic [KIND_W-1:0] KIND_ELLIPSIS = 6'd47;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 6'd48;
    localparam logic [KIND_W-1:0] KIND_NAME     = 6'd49;
    localparam logic [KIND_W-1:0] KIND_STRING   = 6'd50;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 6'd51;
    localparam logic [KIND_W-1:0] KIND_END      = 6'd52;
    localparam logic [KIND_W-1:0] NO_MATCH      = 6'd63;

    localparam logic [LINE_W-1:0] LINE_TOP = {LINE_W{1'b1}};

    typedef enum logic [3:0] {
        MODE_IDLE, MODE_OP1, MODE_OP2, MODE_DOT1, MODE_DOT2, MODE_INT,
        MODE_FRAC, MODE_NAME, MODE_STR, MODE_LCOM, MODE_BCOM, MODE_BSTAR
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic [7:0]        pend_first;
        logic [7:0]        pend_second;
        logic [7:0]        quote;
        logic              escape;
        logic [OFFS_W-1:0] offset;
        logic [OFFS_W-1:0] start_offset;
        logic [LINE_W-1:0] line;
        logic [LINE_W-1:0] start_line;
    } lex_state_t;

    typedef struct packed {
        logic              last;
        logic [LINE_W-1:0] line;
        logic [OFFS_W-1:0] tend;
        logic [OFFS_W-1:0] tstart;
        logic [KIND_W-1:0] kind;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic [KIND_W-1:0] kind_single(input logic [7:0] c);
        logic [KIND_W-1:0] k;
        case (c)
            8'h28: k = 6'd0;   8'h29: k = 6'd1;   8'h5B: k = 6'd2;
            8'h5D: k = 6'd3;   8'h3A: k = 6'd4;   8'h2C: k = 6'd5;
            8'h3B: k = 6'd6;   8'h2B: k = 6'd7;   8'h2D: k = 6'd8;
            8'h2A: k = 6'd9;   8'h2F: k = 6'd10;  8'h7C: k = 6'd11;
            8'h26: k = 6'd12;  8'h3C: k = 6'd13;  8'h3E: k = 6'd14;
            8'h3D: k = 6'd15;  8'h2E: k = 6'd16;  8'h25: k = 6'd17;
            8'h7B: k = 6'd18;  8'h7D: k = 6'd19;  8'h5E: k = 6'd20;
            8'h7E: k = 6'd21;  8'h40: k = 6'd22;  8'h0A: k = 6'd23;
            default: k = KIND_OTHER;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] kind_pair(input logic [7:0] a,
                                                     input logic [7:0] b);
        logic [KIND_W-1:0] k;
        k = NO_MATCH;
        if (b == CH_EQ) begin
            case (a)
                8'h3D: k = 6'd25;  8'h21: k = 6'd26;  8'h3C: k = 6'd27;
                8'h3E: k = 6'd29;  8'h2B: k = 6'd32;  8'h2D: k = 6'd34;
                8'h2A: k = 6'd37;  8'h2F: k = 6'd38;  8'h7C: k = 6'd39;
                8'h25: k = 6'd40;  8'h26: k = 6'd41;  8'h5E: k = 6'd42;
                default: k = NO_MATCH;
            endcase
        end else if (a == 8'h3C && b == 8'h3C) k = 6'd28;
        else if (a == 8'h3E && b == 8'h3E) k = 6'd30;
        else if (a == 8'h2B && b == 8'h2B) k = 6'd31;
        else if (a == 8'h2D && b == 8'h2D) k = 6'd33;
        else if (a == 8'h2D && b == 8'h3E) k = 6'd35;
        else if (a == 8'h2A && b == 8'h2A) k = 6'd36;
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] kind_triple(input logic [7:0] a,
                                                       input logic [7:0] b,
                                                       input logic [7:0] c);
        logic [KIND_W-1:0] k;
        k = NO_MATCH;
        if (a == b && c == CH_EQ) begin
            if (a == 8'h3C) k = 6'd43;
            else if (a == 8'h3E) k = 6'd44;
            else if (a == 8'h2A) k = 6'd45;
        end
        return k;
    endfunction

endpackage

### src/slx_step.sv
// lexer state register and the combinational step that yields up to three tokens
module slx_step (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   take,
    input  logic [7:0]                             char_code,
    input  logic                                   end_of_input,
    output slx_pkg::token_t [slx_pkg::MAX_TOKENS-1:0] tokens,
    output logic [1:0]                             token_count
);
    import slx_pkg::*;

    lex_state_t st_reg, st_next;
    logic [KIND_W-1:0] kk;
    logic [OFFS_W-1:0] pos, so1;
    logic restart;
    logic [1:0] cnt;

    always_comb begin
        st_next = st_reg;
        tokens  = '0;
        cnt     = 2'd0;
        restart = 1'b0;
        pos     = st_reg.offset;
        so1     = st_reg.start_offset + 32'd1;
        kk      = NO_MATCH;
        if (end_of_input) begin
            case (st_reg.mode)
                MODE_OP1: begin
                    tokens[cnt] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                    kind_single(st_reg.pend_first)};
                    cnt = cnt + 2'd1;
                end
                MODE_OP2: begin
                    tokens[cnt] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                    kind_pair(st_reg.pend_first, st_reg.pend_second)};
                    cnt = cnt + 2'd1;
                end
                MODE_DOT1: begin
                    tokens[cnt] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                    KIND_DOT};
                    cnt = cnt + 2'd1;
                end
                MODE_DOT2: begin
                    tokens[0] = '{1'b0, st_reg.start_line, so1, st_reg.start_offset,
                                  KIND_DOT};
                    tokens[1] = '{1'b0, st_reg.start_line, pos, so1, KIND_DOT};
                    cnt = 2'd2;
                end
                MODE_INT, MODE_FRAC: begin
                    tokens[cnt] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                    KIND_NUMBER};
                    cnt = cnt + 2'd1;
                end
                MODE_NAME: begin
                    tokens[cnt] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                    KIND_NAME};
                    cnt = cnt + 2'd1;
                end
                MODE_STR, MODE_BCOM, MODE_BSTAR: begin
                    tokens[cnt] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                    KIND_ERROR};
                    cnt = cnt + 2'd1;
                end
                default: ;
            endcase
            tokens[cnt] = '{1'b0, st_reg.line, pos, pos, KIND_END};
            cnt = cnt + 2'd1;
            st_next.mode   = MODE_IDLE;
            st_next.escape = 1'b0;
        end else begin
            case (st_reg.mode)
                MODE_OP1: begin
                    kk = kind_pair(st_reg.pend_first, char_code);
                    if (st_reg.pend_first == CH_SLASH && char_code == CH_SLASH)
                        st_next.mode = MODE_LCOM;
                    else if (st_reg.pend_first == CH_SLASH && char_code == CH_STAR)
                        st_next.mode = MODE_BCOM;
                    else if (kk != NO_MATCH) begin
                        st_next.pend_second = char_code;
                        st_next.mode = MODE_OP2;
                    end else begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                      kind_single(st_reg.pend_first)};
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                MODE_OP2: begin
                    kk = kind_triple(st_reg.pend_first, st_reg.pend_second, char_code);
                    if (kk != NO_MATCH) begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos + 32'd1,
                                      st_reg.start_offset, kk};
                        cnt = 2'd1;
                        st_next.mode = MODE_IDLE;
                    end else begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                      kind_pair(st_reg.pend_first, st_reg.pend_second)};
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                MODE_DOT1: begin
                    if (is_digit(char_code)) st_next.mode = MODE_FRAC;
                    else if (char_code == CH_DOT) st_next.mode = MODE_DOT2;
                    else begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                      KIND_DOT};
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                MODE_DOT2: begin
                    if (char_code == CH_DOT) begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos + 32'd1,
                                      st_reg.start_offset, KIND_ELLIPSIS};
                        cnt = 2'd1;
                        st_next.mode = MODE_IDLE;
                    end else begin
                        // first dot goes out, second dot is lexed again
                        tokens[0] = '{1'b0, st_reg.start_line, so1, st_reg.start_offset,
                                      KIND_DOT};
                        cnt = 2'd1;
                        st_next.start_offset = so1;
                        if (is_digit(char_code)) st_next.mode = MODE_FRAC;
                        else begin
                            tokens[1] = '{1'b0, st_reg.start_line, pos, so1, KIND_DOT};
                            cnt = 2'd2;
                            restart = 1'b1;
                        end
                    end
                end
                MODE_INT: begin
                    if (is_digit(char_code)) ;
                    else if (char_code == CH_DOT) st_next.mode = MODE_FRAC;
                    else begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                      KIND_NUMBER};
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (!is_digit(char_code)) begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                      KIND_NUMBER};
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                MODE_NAME: begin
                    if (!is_word(char_code)) begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos, st_reg.start_offset,
                                      KIND_NAME};
                        cnt = 2'd1;
                        restart = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (char_code == CH_NL) begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos + 32'd1,
                                      st_reg.start_offset, KIND_ERROR};
                        cnt = 2'd1;
                        st_next.mode = MODE_IDLE;
                        st_next.escape = 1'b0;
                    end else if (st_reg.escape) st_next.escape = 1'b0;
                    else if (char_code == st_reg.quote) begin
                        tokens[0] = '{1'b0, st_reg.start_line, pos + 32'd1,
                                      st_reg.start_offset, KIND_STRING};
                        cnt = 2'd1;
                        st_next.mode = MODE_IDLE;
                    end else if (char_code == CH_BSL) st_next.escape = 1'b1;
                end
                MODE_LCOM: if (char_code == CH_NL) st_next.mode = MODE_IDLE;
                MODE_BCOM: if (char_code == CH_STAR) st_next.mode = MODE_BSTAR;
                MODE_BSTAR: begin
                    if (char_code == CH_SLASH) st_next.mode = MODE_IDLE;
                    else if (char_code != CH_STAR) st_next.mode = MODE_BCOM;
                end
                default: restart = 1'b1;
            endcase
            if (restart) begin
                st_next.mode = MODE_IDLE;
                if (char_code != CH_SPACE && char_code != CH_NL) begin
                    st_next.start_offset = pos;
                    st_next.start_line   = st_reg.line;
                    if (char_code == CH_DOT) st_next.mode = MODE_DOT1;
                    else if (is_digit(char_code)) st_next.mode = MODE_INT;
                    else if (is_word(char_code)) st_next.mode = MODE_NAME;
                    else if (char_code == CH_SQ || char_code == CH_DQ) begin
                        st_next.mode   = MODE_STR;
                        st_next.quote  = char_code;
                        st_next.escape = 1'b0;
                    end else begin
                        st_next.mode       = MODE_OP1;
                        st_next.pend_first = char_code;
                    end
                end
            end
            if (char_code == CH_NL && st_reg.line != LINE_TOP)
                st_next.line = st_reg.line + 24'd1;
            st_next.offset = st_reg.offset + 32'd1;
        end
        if (cnt != 2'd0) tokens[cnt - 2'd1].last = 1'b1;
        token_count = cnt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{MODE_IDLE, 8'd0, 8'd0, 8'd0, 1'b0, 32'd0, 32'd0, 24'd1, 24'd0};
        end else if (take) begin
            st_reg <= st_next;
        end
    end

endmodule

### src/slx_fifo.sv
// result queue: takes up to three tokens per cycle while three entries are free, hands out one per transaction
module slx_fifo (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      wr_en,
    input  slx_pkg::token_t [slx_pkg::MAX_TOKENS-1:0] wr_tokens,
    input  logic [1:0]                                wr_count,
    output logic                                      has_room,
    output logic                                      rd_valid,
    input  logic                                      rd_ready,
    output slx_pkg::token_t                           rd_token
);
    import slx_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    token_t mem [FIFO_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   count_reg, count_next;
    logic [PW:0]   add;
    logic          pop;

    assign pop      = rd_valid && rd_ready;
    assign add      = wr_en ? {{(PW-1){1'b0}}, wr_count} : '0;
    assign rd_valid = count_reg != '0;
    assign rd_token = mem[rp_reg];
    assign has_room = count_reg <= (PW+1)'(FIFO_DEPTH - MAX_TOKENS);
    assign count_next = count_reg + add - {{PW{1'b0}}, pop};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            for (int i = 0; i < MAX_TOKENS; i++) begin
                if (2'(i) < wr_count) mem[wp_reg + PW'(i)] <= wr_tokens[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            wp_reg    <= wp_reg + add[PW-1:0];
            rp_reg    <= rp_reg + PW'(pop);
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (PW+1)'(FIFO_DEPTH)) else $error("queue overfilled");
    a_write_room: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> has_room) else $error("write without room");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (!wr_en && !pop) |=> $stable(count_reg)) else $error("count drifted");

endmodule

### src/source_code_lexer.sv
// top level of the streaming source lexer
// usage:
//   s_ channel carries one source byte per transaction in s_tdata; s_tuser high
//   marks end of input (byte ignored), which flushes the pending token and
//   emits the end marker.
//   m_ channel carries one token per transaction; m_tlast marks the last token
//   produced by one input transaction. an input may yield zero to three tokens.
// output: tokens are queued as their input is taken and leave in order on m_.
// throughput: one input per cycle; the output side delivers one token per
//   cycle, so a burst of multi-token inputs is absorbed by an eight-entry
//   result queue. s_tready drops when fewer than three entries are free.
// stall: while m_tready is low the queue fills and then s_tready goes low;
//   no token is lost or repeated.
// reset: aresetn low for one clock empties the queue, returns the lexer to
//   between tokens, offset zero, line one.
module source_code_lexer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // token_kind[5:0], token_start[37:6],
                                   // token_end[69:38], token_line[93:70], zero
    output logic        m_tlast
);
    import slx_pkg::*;

    token_t [MAX_TOKENS-1:0] toks;
    logic [1:0] tok_count;
    logic take;
    token_t head;

    assign take = s_tvalid && s_tready;

    slx_step u_step (
        .aclk(aclk), .aresetn(aresetn), .take(take),
        .char_code(s_tdata), .end_of_input(s_tuser),
        .tokens(toks), .token_count(tok_count)
    );

    slx_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .wr_en(take),
        .wr_tokens(toks), .wr_count(tok_count), .has_room(s_tready),
        .rd_valid(m_tvalid), .rd_ready(m_tready), .rd_token(head)
    );

    assign m_tdata = {2'b00, head.line, head.tend, head.tstart, head.kind};
    assign m_tlast = head.last;

    a_end_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        (take && s_tuser) |=> m_tvalid) else $error("end mark gave no token");
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled token changed");
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> head.kind <= KIND_END) else $error("bad token kind");

endmodule

### test/source_code_lexer_tb.sv
// testbench for the streaming source lexer: predicted tokens checked against m_ output
module source_code_lexer_tb;
    import slx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    // lexer modes of the predictor
    typedef enum int {
        LX_IDLE, LX_OP1, LX_OP2, LX_DOT1, LX_DOT2, LX_INT, LX_FRAC, LX_NAME,
        LX_STR, LX_LCOM, LX_BCOM, LX_BSTAR
    } lx_mode_e;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFFS_W-1:0] tstart;
        logic [OFFS_W-1:0] tend;
        logic [LINE_W-1:0] line;
        logic              last;
    } tok_s;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic        m_tlast;

    source_code_lexer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #10 aclk = ~aclk;

    // predictor state
    lx_mode_e          p_mode;
    logic [7:0]        p_first, p_second, p_quote;
    logic              p_escape;
    logic [OFFS_W-1:0] p_offset, p_start;
    logic [LINE_W-1:0] p_line, p_start_line;

    tok_s pending_tokens[$];
    tok_s step_tokens[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   calm = 0;

    function automatic bit digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit word_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic [KIND_W-1:0] single_kind(logic [7:0] c);
        case (c)
            "(": return 0;  ")": return 1;  "[": return 2;  "]": return 3;
            ":": return 4;  ",": return 5;  ";": return 6;  "+": return 7;
            "-": return 8;  "*": return 9;  "/": return 10; "|": return 11;
            "&": return 12; "<": return 13; ">": return 14; "=": return 15;
            ".": return 16; "%": return 17; "{": return 18; "}": return 19;
            "^": return 20; "~": return 21; "@": return 22; 8'h0A: return 23;
            default: return KIND_OTHER;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] pair_kind(logic [7:0] a, logic [7:0] b);
        if (b == "=") begin
            case (a)
                "=": return 25; "!": return 26; "<": return 27; ">": return 29;
                "+": return 32; "-": return 34; "*": return 37; "/": return 38;
                "|": return 39; "%": return 40; "&": return 41; "^": return 42;
                default: return NO_MATCH;
            endcase
        end
        if (a == "<" && b == "<") return 28;
        if (a == ">" && b == ">") return 30;
        if (a == "+" && b == "+") return 31;
        if (a == "-" && b == "-") return 33;
        if (a == "-" && b == ">") return 35;
        if (a == "*" && b == "*") return 36;
        return NO_MATCH;
    endfunction

    function automatic logic [KIND_W-1:0] triple_kind(logic [7:0] a, logic [7:0] b,
                                                      logic [7:0] c);
        if (a != b || c != "=") return NO_MATCH;
        if (a == "<") return 43;
        if (a == ">") return 44;
        if (a == "*") return 45;
        return NO_MATCH;
    endfunction

    task automatic note_token(logic [KIND_W-1:0] k, logic [OFFS_W-1:0] s,
                              logic [OFFS_W-1:0] e, logic [LINE_W-1:0] ln);
        tok_s t;
        t = '{k, s, e, ln, 1'b0};
        if (step_tokens.size() < MAX_TOKENS) step_tokens.push_back(t);
    endtask

    task automatic reset_lexer_model();
        p_mode = LX_IDLE; p_first = 0; p_second = 0; p_quote = 0; p_escape = 0;
        p_offset = 0; p_start = 0; p_line = 1; p_start_line = 0;
    endtask

    task automatic scan_byte(logic [7:0] c, logic [OFFS_W-1:0] pos);
        bit again;
        logic [KIND_W-1:0] t;
        again = 1;
        while (again) begin
            again = 0;
            case (p_mode)
                LX_OP1: begin
                    if (p_first == "/" && c == "/") p_mode = LX_LCOM;
                    else if (p_first == "/" && c == "*") p_mode = LX_BCOM;
                    else if (pair_kind(p_first, c) != NO_MATCH) begin
                        p_second = c; p_mode = LX_OP2;
                    end else begin
                        note_token(single_kind(p_first), p_start, pos, p_start_line);
                        p_mode = LX_IDLE; again = 1;
                    end
                end
                LX_OP2: begin
                    t = triple_kind(p_first, p_second, c);
                    if (t != NO_MATCH) begin
                        note_token(t, p_start, pos + 1, p_start_line);
                        p_mode = LX_IDLE;
                    end else begin
                        note_token(pair_kind(p_first, p_second), p_start, pos, p_start_line);
                        p_mode = LX_IDLE; again = 1;
                    end
                end
                LX_DOT1: begin
                    if (digit_c(c)) p_mode = LX_FRAC;
                    else if (c == ".") p_mode = LX_DOT2;
                    else begin
                        note_token(KIND_DOT, p_start, pos, p_start_line);
                        p_mode = LX_IDLE; again = 1;
                    end
                end
                LX_DOT2: begin
                    if (c == ".") begin
                        note_token(KIND_ELLIPSIS, p_start, pos + 1, p_start_line);
                        p_mode = LX_IDLE;
                    end else begin
                        // second dot is lexed again as a fresh dot
                        note_token(KIND_DOT, p_start, p_start + 1, p_start_line);
                        p_start = p_start + 1;
                        p_mode = LX_DOT1; again = 1;
                    end
                end
                LX_INT: begin
                    if (c == ".") p_mode = LX_FRAC;
                    else if (!digit_c(c)) begin
                        note_token(KIND_NUMBER, p_start, pos, p_start_line);
                        p_mode = LX_IDLE; again = 1;
                    end
                end
                LX_FRAC, LX_NAME: begin
                    if (p_mode == LX_FRAC ? !digit_c(c) : !word_c(c)) begin
                        note_token(p_mode == LX_FRAC ? KIND_NUMBER : KIND_NAME,
                                   p_start, pos, p_start_line);
                        p_mode = LX_IDLE; again = 1;
                    end
                end
                LX_STR: begin
                    if (c == 8'h0A) begin
                        note_token(KIND_ERROR, p_start, pos + 1, p_start_line);
                        p_mode = LX_IDLE; p_escape = 0;
                    end else if (p_escape) p_escape = 0;
                    else if (c == p_quote) begin
                        note_token(KIND_STRING, p_start, pos + 1, p_start_line);
                        p_mode = LX_IDLE;
                    end else if (c == "\\") p_escape = 1;
                end
                LX_LCOM: if (c == 8'h0A) p_mode = LX_IDLE;
                LX_BCOM: if (c == "*") p_mode = LX_BSTAR;
                LX_BSTAR: begin
                    if (c == "/") p_mode = LX_IDLE;
                    else if (c != "*") p_mode = LX_BCOM;
                end
                default: begin
                    p_mode = LX_IDLE;
                    if (c != " " && c != 8'h0A) begin
                        p_start = pos; p_start_line = p_line;
                        if (c == ".") p_mode = LX_DOT1;
                        else if (digit_c(c)) p_mode = LX_INT;
                        else if (word_c(c)) p_mode = LX_NAME;
                        else if (c == "'" || c == "\"") begin
                            p_mode = LX_STR; p_quote = c; p_escape = 0;
                        end else begin
                            p_mode = LX_OP1; p_first = c;
                        end
                    end
                end
            endcase
        end
    endtask

    task automatic flush_lexer();
        logic [OFFS_W-1:0] e;
        e = p_offset;
        case (p_mode)
            LX_OP1: note_token(single_kind(p_first), p_start, e, p_start_line);
            LX_OP2: note_token(pair_kind(p_first, p_second), p_start, e, p_start_line);
            LX_DOT1: note_token(KIND_DOT, p_start, e, p_start_line);
            LX_DOT2: begin
                note_token(KIND_DOT, p_start, p_start + 1, p_start_line);
                note_token(KIND_DOT, p_start + 1, e, p_start_line);
            end
            LX_INT, LX_FRAC: note_token(KIND_NUMBER, p_start, e, p_start_line);
            LX_NAME: note_token(KIND_NAME, p_start, e, p_start_line);
            LX_STR, LX_BCOM, LX_BSTAR: note_token(KIND_ERROR, p_start, e, p_start_line);
            default: ;
        endcase
        note_token(KIND_END, e, e, p_line);
        p_mode = LX_IDLE; p_escape = 0;
    endtask

    task automatic predict_tokens(logic [7:0] c, logic eoi);
        step_tokens.delete();
        if (eoi) flush_lexer();
        else begin
            scan_byte(c, p_offset);
            if (c == 8'h0A && p_line != LINE_TOP) p_line = p_line + 1;
            p_offset = p_offset + 1;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endtask

    // one input transaction, with a random gap before it unless calm
    // s_tvalid stays high after acceptance until the caller drives it again
    task automatic send_byte(logic [7:0] c, logic eoi = 1'b0);
        while (!calm && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tokens(c, eoi);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_tokens.size() > 0) @(posedge aclk);
    endtask

    // token checker
    always @(posedge aclk) begin
        tok_s exp_t;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("unexpected token %h", m_tdata);
                errors++;
            end else begin
                exp_t = pending_tokens.pop_front();
                if (m_tdata[5:0] != exp_t.kind) begin
                    $error("token_kind exp %0d got %0d", exp_t.kind, m_tdata[5:0]); errors++;
                end
                if (m_tdata[37:6] != exp_t.tstart) begin
                    $error("token_start exp %0d got %0d", exp_t.tstart, m_tdata[37:6]);
                    errors++;
                end
                if (m_tdata[69:38] != exp_t.tend) begin
                    $error("token_end exp %0d got %0d", exp_t.tend, m_tdata[69:38]); errors++;
                end
                if (m_tdata[93:70] != exp_t.line) begin
                    $error("token_line exp %0d got %0d", exp_t.line, m_tdata[93:70]); errors++;
                end
                if (m_tdata[95:94] != 2'b00) begin
                    $error("pad exp 0 got %0d", m_tdata[95:94]); errors++;
                end
                if (m_tlast != exp_t.last) begin
                    $error("last_of_run exp %0d got %0d", exp_t.last, m_tlast); errors++;
                end
            end
        end
    end

    // result side backpressure
    always @(posedge aclk) m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 26);

    // watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("source_code_lexer regression: fail");
            $finish;
        end
    end

    task automatic test_operators();
        send_text("( ) [ ] : , ; ~ @ { } ! ? == != <= << >= >> ++ += -- -= -> ** *= ");
        send_text("/= |= %= &= ^= <<= >>= **= + - * / | & < > = % ^ ");
        send_byte(8'd1, 1'b1);
    endtask

    task automatic test_literals();
        send_text("abc _Z 0123 4.56 .5 7. ... .. ..5 . \n\t\r");
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'h80);
        send_text("'a\\'b' \"x\\\"y\" 'bad\n\"esc\\\n// comment <<=\n/* x ** */ q");
        send_byte(8'h00, 1'b1);
        send_text("/* open *");
        send_byte(8'hAA, 1'b1);
        send_text("\"open");
        send_byte(8'h00, 1'b1);
        send_text("/**/");
        send_byte(8'h00, 1'b1);
        send_text("..");
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b1);
    endtask

    function automatic string random_fragment();
        string frags[$];
        string s;
        int n;
        frags = '{"x", "_n", "12", "3.4", ".7", "..", "...", "'s\\q'", "\"t\"", "\"u\n",
                  "// c\n", "/* b * */", "<<=", ">>", "**=", "->", "!=", " ", "\n", "/",
                  "*", ".", "=", "+", "-", "<", ">", "%=", "^", "&", "|="};
        s = frags[$urandom_range(frags.size() - 1)];
        if ($urandom_range(3) == 0) begin
            n = $urandom_range(255);
            s = {s, string'(byte'(n == 0 ? 8'h09 : n))};
        end
        return s;
    endfunction

    task automatic test_random();
        string s;
        int sent;
        bit drained;
        sent = 0;
        drained = 0;
        while (sent < 80) begin
            if (sent > 20 && sent < 50) calm = 1; else calm = 0;
            if ($urandom_range(9) < 8) s = random_fragment();
            else s = string'(byte'($urandom_range(255)));
            foreach (s[i]) send_byte(s[i]);
            sent += s.len();
            if ($urandom_range(29) == 0) send_byte(8'($urandom_range(255)), 1'b1);
            if (!drained && sent > 60) begin
                wait_drained();
                drained = 1;
            end
        end
        calm = 0;
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        reset_lexer_model();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_operators();
        test_literals();
        test_random();
        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_tokens.size() == 0)
            $display("source_code_lexer regression: pass");
        else
            $display("source_code_lexer regression: fail");
        $finish;
    end
endmodule
